[src/slm_pkg.sv]
`default_nettype none
// ============================================================================
// slm_pkg: shared types and constants of the layered slot list manager
// Sizes, link encoding, command and status codes, and memory port structs.
// ============================================================================
package slm_pkg;

  localparam int ENTRIES = 64;
  localparam int LAYERS  = 8;

  localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LIDX_W  = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int COUNT_W = $clog2(ENTRIES + 1);
  localparam int LINK_W  = 7;
  localparam int LAYER_W = 3;
  localparam int HANDLE_W = 6;

  typedef logic [LINK_W-1:0]  link_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [LIDX_W-1:0]  lidx_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam link_t LINK_END = link_t'(127);

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_WALK    = 2'd2,
    ACT_NONE    = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOT_USED = 2'd2,
    STAT_NO_WALK  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_AL_RD,
    S_AL_LINK,
    S_RL_RD,
    S_RL_PREV,
    S_RL_NEXT,
    S_WK_LAYER,
    S_WK_SLOT
  } state_t;

  // One slot entry as stored in the slot memory.
  typedef struct packed {
    link_t               nxt_link;
    link_t               prv_link;
    logic [LAYER_W-1:0]  layer;
    logic                used;
  } ent_t;

  // Write command with per-field enables (layer and used travel together).
  typedef struct packed {
    logic  we_next;
    logic  we_prev;
    logic  we_info;
    slot_t addr;
    ent_t  data;
  } mem_wr_t;

  function automatic logic link_ok(input link_t l);
    return (32'(l) < ENTRIES);
  endfunction

  function automatic slot_t link_slot(input link_t l);
    return l[SLOT_W-1:0];
  endfunction

  function automatic lidx_t sat_layer(input logic [LAYER_W-1:0] l);
    if (32'(l) >= LAYERS) begin
      return lidx_t'(LAYERS - 1);
    end
    return lidx_t'(l);
  endfunction

  function automatic logic [LAYER_W-1:0] lidx_field(input lidx_t l);
    logic [7:0] wide;
    wide = 8'(l);
    return wide[LAYER_W-1:0];
  endfunction

endpackage
`default_nettype wire

[src/slm_mem.sv]
`default_nettype none
// ============================================================================
// slm_mem: slot entry memory
// One write port with field enables, one read port with registered data.
// ============================================================================
module slm_mem (
  input  wire logic             clk,
  input  wire slm_pkg::mem_wr_t wr,
  input  wire logic             rd_en,
  input  wire slm_pkg::slot_t   rd_addr,
  output slm_pkg::ent_t         rd_data
);

  slm_pkg::link_t                     next_mem [slm_pkg::ENTRIES];
  slm_pkg::link_t                     prev_mem [slm_pkg::ENTRIES];
  logic [slm_pkg::LAYER_W:0]          info_mem [slm_pkg::ENTRIES];
  slm_pkg::ent_t                      rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we_next) begin
      next_mem[wr.addr] <= wr.data.nxt_link;
    end
    if (wr.we_prev) begin
      prev_mem[wr.addr] <= wr.data.prv_link;
    end
    if (wr.we_info) begin
      info_mem[wr.addr] <= {wr.data.layer, wr.data.used};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r.nxt_link <= next_mem[rd_addr];
      rd_data_r.prv_link <= prev_mem[rd_addr];
      {rd_data_r.layer, rd_data_r.used} <= info_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[src/slm_ctrl.sv]
`default_nettype none
// ============================================================================
// slm_ctrl: list sequencer
// Runs allocate, release and walk as read-modify-write steps on the slot
// memory and keeps the free head, layer heads and tails and the used count.
// ============================================================================
module slm_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_action,
  input  wire logic [slm_pkg::LAYER_W-1:0]   in_layer,
  input  wire logic [slm_pkg::HANDLE_W-1:0]  in_handle,
  output logic                               out_valid,
  output logic [slm_pkg::HANDLE_W-1:0]       out_slot,
  output logic [slm_pkg::LAYER_W-1:0]        out_slot_layer,
  output logic [1:0]                         out_status,
  output logic                               out_last,
  output slm_pkg::mem_wr_t                   mem_wr,
  output logic                               mem_rd_en,
  output slm_pkg::slot_t                     mem_rd_addr,
  input  wire slm_pkg::ent_t                 mem_rd_data
);

  slm_pkg::state_t state_r, state_nxt;
  slm_pkg::link_t  free_head_r, free_head_nxt;
  slm_pkg::count_t used_cnt_r, used_cnt_nxt;
  slm_pkg::count_t cnt_r, cnt_nxt;
  slm_pkg::lidx_t  lay_r, lay_nxt;
  slm_pkg::slot_t  slot_r, slot_nxt;
  slm_pkg::link_t  prv_r, prv_nxt;
  slm_pkg::link_t  nxt_r, nxt_nxt;
  slm_pkg::link_t  head_r [slm_pkg::LAYERS];
  slm_pkg::link_t  tail_r [slm_pkg::LAYERS];

  logic            head_we, tail_we;
  slm_pkg::link_t  head_wdata, tail_wdata;
  slm_pkg::link_t  cur_head, cur_tail;

  logic                            out_valid_r, out_valid_nxt;
  logic [slm_pkg::HANDLE_W-1:0]    out_slot_r, out_slot_nxt;
  logic [slm_pkg::LAYER_W-1:0]     out_layer_r, out_layer_nxt;
  logic [1:0]                      out_status_r, out_status_nxt;
  logic                            out_last_r, out_last_nxt;

  logic            walk_last;
  slm_pkg::count_t cnt_inc;

  assign cur_head  = head_r[lay_r];
  assign cur_tail  = tail_r[lay_r];
  assign cnt_inc   = cnt_r + slm_pkg::count_t'(1);
  assign walk_last = (cnt_inc == used_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slm_pkg::S_CLEAR;
      free_head_r <= '0;
      used_cnt_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      used_cnt_r  <= used_cnt_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lay_r        <= lay_nxt;
    slot_r       <= slot_nxt;
    prv_r        <= prv_nxt;
    nxt_r        <= nxt_nxt;
    out_slot_r   <= out_slot_nxt;
    out_layer_r  <= out_layer_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < slm_pkg::LAYERS; i++) begin
        head_r[i] <= slm_pkg::LINK_END;
        tail_r[i] <= slm_pkg::LINK_END;
      end
    end else begin
      if (head_we) begin
        head_r[lay_r] <= head_wdata;
      end
      if (tail_we) begin
        tail_r[lay_r] <= tail_wdata;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    free_head_nxt  = free_head_r;
    used_cnt_nxt   = used_cnt_r;
    cnt_nxt        = cnt_r;
    lay_nxt        = lay_r;
    slot_nxt       = slot_r;
    prv_nxt        = prv_r;
    nxt_nxt        = nxt_r;
    head_we        = 1'b0;
    tail_we        = 1'b0;
    head_wdata     = slm_pkg::LINK_END;
    tail_wdata     = slm_pkg::LINK_END;
    mem_wr         = '0;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = slot_r;
    out_valid_nxt  = 1'b0;
    out_slot_nxt   = out_slot_r;
    out_layer_nxt  = out_layer_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      slm_pkg::S_CLEAR: begin
        // Write every entry back to its reset value, one per cycle.
        mem_wr.we_next = 1'b1;
        mem_wr.we_prev = 1'b1;
        mem_wr.we_info = 1'b1;
        mem_wr.addr    = cnt_r[slm_pkg::SLOT_W-1:0];
        mem_wr.data.nxt_link = (32'(cnt_inc) < slm_pkg::ENTRIES) ?
                               slm_pkg::link_t'(cnt_inc) : slm_pkg::LINK_END;
        mem_wr.data.prv_link = slm_pkg::LINK_END;
        mem_wr.data.layer    = '0;
        mem_wr.data.used     = 1'b0;
        if (32'(cnt_inc) >= slm_pkg::ENTRIES) begin
          cnt_nxt   = '0;
          state_nxt = slm_pkg::S_IDLE;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end

      slm_pkg::S_IDLE: begin
        if (start) begin
          unique case (slm_pkg::act_t'(in_action))
            slm_pkg::ACT_ALLOC: begin
              lay_nxt  = slm_pkg::sat_layer(in_layer);
              slot_nxt = slm_pkg::link_slot(free_head_r);
              if (!slm_pkg::link_ok(free_head_r)) begin
                out_valid_nxt  = 1'b1;
                out_slot_nxt   = '0;
                out_layer_nxt  = slm_pkg::lidx_field(slm_pkg::sat_layer(in_layer));
                out_status_nxt = slm_pkg::STAT_EMPTY;
                out_last_nxt   = 1'b1;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = slm_pkg::link_slot(free_head_r);
                state_nxt   = slm_pkg::S_AL_RD;
              end
            end
            slm_pkg::ACT_RELEASE: begin
              slot_nxt = slm_pkg::link_slot(slm_pkg::link_t'(in_handle));
              if (!slm_pkg::link_ok(slm_pkg::link_t'(in_handle))) begin
                out_valid_nxt  = 1'b1;
                out_slot_nxt   = in_handle;
                out_layer_nxt  = '0;
                out_status_nxt = slm_pkg::STAT_NOT_USED;
                out_last_nxt   = 1'b1;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = slm_pkg::link_slot(slm_pkg::link_t'(in_handle));
                state_nxt   = slm_pkg::S_RL_RD;
              end
            end
            slm_pkg::ACT_WALK: begin
              if (used_cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_slot_nxt   = '0;
                out_layer_nxt  = '0;
                out_status_nxt = slm_pkg::STAT_NO_WALK;
                out_last_nxt   = 1'b1;
              end else begin
                lay_nxt   = slm_pkg::lidx_t'(slm_pkg::LAYERS - 1);
                cnt_nxt   = '0;
                state_nxt = slm_pkg::S_WK_LAYER;
              end
            end
            slm_pkg::ACT_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end

      slm_pkg::S_AL_RD: begin
        // Pop the free head and append it at the layer tail.
        free_head_nxt = mem_rd_data.nxt_link;
        mem_wr.we_next = 1'b1;
        mem_wr.we_prev = 1'b1;
        mem_wr.we_info = 1'b1;
        mem_wr.addr    = slot_r;
        mem_wr.data.nxt_link = slm_pkg::LINK_END;
        mem_wr.data.prv_link = cur_tail;
        mem_wr.data.layer    = slm_pkg::lidx_field(lay_r);
        mem_wr.data.used     = 1'b1;
        tail_we    = 1'b1;
        tail_wdata = slm_pkg::link_t'(slot_r);
        used_cnt_nxt = used_cnt_r + slm_pkg::count_t'(1);
        prv_nxt      = cur_tail;
        out_valid_nxt  = 1'b1;
        out_slot_nxt   = slm_pkg::HANDLE_W'(slot_r);
        out_layer_nxt  = slm_pkg::lidx_field(lay_r);
        out_status_nxt = slm_pkg::STAT_OK;
        out_last_nxt   = 1'b1;
        if (slm_pkg::link_ok(cur_tail)) begin
          state_nxt = slm_pkg::S_AL_LINK;
        end else begin
          head_we    = 1'b1;
          head_wdata = slm_pkg::link_t'(slot_r);
          state_nxt  = slm_pkg::S_IDLE;
        end
      end

      slm_pkg::S_AL_LINK: begin
        mem_wr.we_next       = 1'b1;
        mem_wr.addr          = slm_pkg::link_slot(prv_r);
        mem_wr.data.nxt_link = slm_pkg::link_t'(slot_r);
        state_nxt            = slm_pkg::S_IDLE;
      end

      slm_pkg::S_RL_RD: begin
        if (!mem_rd_data.used) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = slm_pkg::HANDLE_W'(slot_r);
          out_layer_nxt  = '0;
          out_status_nxt = slm_pkg::STAT_NOT_USED;
          out_last_nxt   = 1'b1;
          state_nxt      = slm_pkg::S_IDLE;
        end else begin
          lay_nxt = slm_pkg::sat_layer(mem_rd_data.layer);
          prv_nxt = mem_rd_data.prv_link;
          nxt_nxt = mem_rd_data.nxt_link;
          // The released slot goes to the head of the free list.
          mem_wr.we_next = 1'b1;
          mem_wr.we_prev = 1'b1;
          mem_wr.we_info = 1'b1;
          mem_wr.addr    = slot_r;
          mem_wr.data.nxt_link = free_head_r;
          mem_wr.data.prv_link = slm_pkg::LINK_END;
          mem_wr.data.layer    = mem_rd_data.layer;
          mem_wr.data.used     = 1'b0;
          free_head_nxt = slm_pkg::link_t'(slot_r);
          if (used_cnt_r != '0) begin
            used_cnt_nxt = used_cnt_r - slm_pkg::count_t'(1);
          end
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = slm_pkg::HANDLE_W'(slot_r);
          out_layer_nxt  = slm_pkg::lidx_field(slm_pkg::sat_layer(mem_rd_data.layer));
          out_status_nxt = slm_pkg::STAT_OK;
          out_last_nxt   = 1'b1;
          state_nxt      = slm_pkg::S_RL_PREV;
        end
      end

      slm_pkg::S_RL_PREV: begin
        if (slm_pkg::link_ok(prv_r)) begin
          mem_wr.we_next       = 1'b1;
          mem_wr.addr          = slm_pkg::link_slot(prv_r);
          mem_wr.data.nxt_link = nxt_r;
        end
        if (cur_head == slm_pkg::link_t'(slot_r)) begin
          head_we    = 1'b1;
          head_wdata = nxt_r;
        end
        if (cur_tail == slm_pkg::link_t'(slot_r)) begin
          tail_we    = 1'b1;
          tail_wdata = prv_r;
        end
        state_nxt = slm_pkg::S_RL_NEXT;
      end

      slm_pkg::S_RL_NEXT: begin
        if (slm_pkg::link_ok(nxt_r)) begin
          mem_wr.we_prev       = 1'b1;
          mem_wr.addr          = slm_pkg::link_slot(nxt_r);
          mem_wr.data.prv_link = prv_r;
        end
        state_nxt = slm_pkg::S_IDLE;
      end

      slm_pkg::S_WK_LAYER: begin
        if (slm_pkg::link_ok(cur_head)) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = slm_pkg::link_slot(cur_head);
          slot_nxt    = slm_pkg::link_slot(cur_head);
          state_nxt   = slm_pkg::S_WK_SLOT;
        end else if (lay_r == '0) begin
          state_nxt = slm_pkg::S_IDLE;
        end else begin
          lay_nxt = lay_r - slm_pkg::lidx_t'(1);
        end
      end

      slm_pkg::S_WK_SLOT: begin
        out_valid_nxt  = 1'b1;
        out_slot_nxt   = slm_pkg::HANDLE_W'(slot_r);
        out_layer_nxt  = slm_pkg::lidx_field(lay_r);
        out_status_nxt = slm_pkg::STAT_OK;
        out_last_nxt   = walk_last;
        cnt_nxt        = cnt_inc;
        priority if (walk_last) begin
          state_nxt = slm_pkg::S_IDLE;
        end else if (slm_pkg::link_ok(mem_rd_data.nxt_link)) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = slm_pkg::link_slot(mem_rd_data.nxt_link);
          slot_nxt    = slm_pkg::link_slot(mem_rd_data.nxt_link);
        end else if (lay_r == '0) begin
          state_nxt = slm_pkg::S_IDLE;
        end else begin
          lay_nxt   = lay_r - slm_pkg::lidx_t'(1);
          state_nxt = slm_pkg::S_WK_LAYER;
        end
      end

      default: begin
        state_nxt = slm_pkg::S_IDLE;
      end
    endcase
  end

  assign busy           = (state_r != slm_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_slot       = out_slot_r;
  assign out_slot_layer = out_layer_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

[src/layered_slot_list_manager_top.sv]
`default_nettype none
// ============================================================================
// layered_slot_list_manager_top: pool of slots on a free list and per-layer
// doubly linked lists, with allocate, release and walk commands.
// ============================================================================
// Results cannot be stalled: output registers show them in the cycle after the start
//   transfer for an empty pool or an empty walk, and behind the memory read register
//   for other allocates and releases. Busy states: allocate S_AL_RD (+S_AL_LINK if
//   the layer had a tail), release S_RL_RD, S_RL_PREV, S_RL_NEXT (only S_RL_RD for
//   an unused slot), walk S_WK_SLOT per result and S_WK_LAYER per layer from the top
//   layer down to the lowest non-empty one. Reset: rst_n starts a slot memory sweep with busy high.
// ============================================================================
module layered_slot_list_manager_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [2:0]  in_layer,
  input  wire logic [5:0]  in_handle,
  output logic             out_valid,
  output logic [5:0]       out_slot,
  output logic [2:0]       out_slot_layer,
  output logic [1:0]       out_status,
  output logic             out_last
);

  // The slot memory holds next link, previous link, layer and in-use flag
  // of every slot. The sequencer owns the single read and write port, so
  // each command runs to completion before the next start is taken and no
  // read can overtake a pending write to the same entry.
  slm_pkg::mem_wr_t mem_wr;
  logic             mem_rd_en;
  slm_pkg::slot_t   mem_rd_addr;
  slm_pkg::ent_t    mem_rd_data;

  // Results leave from registers in the sequencer, shown for exactly one
  // cycle with out_valid; the receiver takes every transfer.
  slm_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_layer       (in_layer),
    .in_handle      (in_handle),
    .out_valid      (out_valid),
    .out_slot       (out_slot),
    .out_slot_layer (out_slot_layer),
    .out_status     (out_status),
    .out_last       (out_last),
    .mem_wr         (mem_wr),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data)
  );

  slm_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule
`default_nettype wire

[src/slm_checker.sv]
`default_nettype none
// ============================================================================
// slm_checker: port level checks of the slot list manager
// Watches commands and results over time at the top level ports.
// ============================================================================
module slm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] in_action,
  input wire logic       out_valid,
  input wire logic [1:0] out_status,
  input wire logic       out_last
);

  // Reset leaves no result on the port and starts the memory sweep.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && busy)
    else $error("result or idle right after reset");

  // Every failure status ends its command.
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != slm_pkg::STAT_OK |-> out_last)
    else $error("error status without last");

  // More walk results to come means the block is still working.
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final result while idle");

  // A real command gives a result or keeps the block busy.
  a_cmd_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_action != slm_pkg::ACT_NONE |=> busy || out_valid)
    else $error("accepted command vanished");

  // Nothing follows a final result unless a new command was taken.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && !(start && !busy) |=> !out_valid)
    else $error("result after final transfer");

endmodule

bind layered_slot_list_manager_top slm_checker u_slm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_action  (in_action),
  .out_valid  (out_valid),
  .out_status (out_status),
  .out_last   (out_last)
);
`default_nettype wire
